@@ hw/rtl/mpwa_pkg.sv @@
// ----------------------------------------------------------------------------
// mpwa_pkg
// Shared widths, constants and types of the windowed mechanical power
// average block.
// ----------------------------------------------------------------------------
package mpwa_pkg;

    // window length and the widths that follow from it
    localparam int WINDOW    = 10;
    localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);

    // sample and power widths
    localparam int POS_W     = 24;
    localparam int FRC_W     = 24;
    localparam int DIFF_W    = POS_W + 1;
    localparam int PROD_W    = DIFF_W + FRC_W;
    localparam int DOT_W     = PROD_W + 1;
    localparam int MAG_W     = DOT_W - 1;
    localparam int LO_W      = 25;
    localparam int HI_W      = MAG_W - LO_W;
    localparam int RATE_W    = 20;
    localparam int PLO_W     = LO_W + RATE_W;
    localparam int PHI_W     = HI_W + RATE_W;
    localparam int FULL_W    = HI_W + RATE_W + LO_W;
    localparam int POW_W     = 48;
    localparam int AVG_W     = POW_W - 1;
    localparam int SUM_W     = POW_W + CNT_W;

    // divider: DIV_BITS quotient bits per cycle
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = (SUM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_PAD_W = DIV_STEPS * DIV_BITS;
    localparam int DCNT_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);
    localparam logic REG_SAMPLE_RATE = 1'b0;

    localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_LANE,
        S_MERGE,
        S_MUL_LO,
        S_MUL_HI,
        S_SAT,
        S_PUSH,
        S_START,
        S_DIV,
        S_OUT
    } t_state;

    // step controls for the merging and scaling stage
    typedef struct packed {
        logic merge;
        logic mul_lo;
        logic mul_hi;
        logic sat;
    } t_scale_ctrl;

endpackage

@@ hw/rtl/mpwa_lane.sv @@
// ----------------------------------------------------------------------------
// mpwa_lane
// One axis: position change times force, registered.
// ----------------------------------------------------------------------------
module mpwa_lane
    import mpwa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [POS_W-1:0]  i_pos,
    input  logic signed [POS_W-1:0]  i_last,
    input  logic signed [FRC_W-1:0]  i_force,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] r_prod;

    assign diff = DIFF_W'(i_pos) - DIFF_W'(i_last);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(diff) * PROD_W'(i_force);
        end
    end

    assign o_prod = r_prod;

endmodule

@@ hw/rtl/mpwa_scale.sv @@
// ----------------------------------------------------------------------------
// mpwa_scale
// Merge the three lane products into the dot product, scale it by the
// sample rate in two partial products and saturate to 48 bits.
// ----------------------------------------------------------------------------
module mpwa_scale
    import mpwa_pkg::*;
(
    input  logic                     i_clk,
    input  t_scale_ctrl              i_ctrl,
    input  logic signed [PROD_W-1:0] i_prod_x,
    input  logic signed [PROD_W-1:0] i_prod_y,
    input  logic signed [PROD_W-1:0] i_prod_z,
    input  logic [RATE_W-1:0]        i_rate,
    output logic signed [POW_W-1:0]  o_power
);

    logic signed [DOT_W-1:0] dot;
    logic [DOT_W-1:0]        dot_abs;
    logic [FULL_W-1:0]       full;
    logic                    sat_pos;
    logic                    sat_neg;

    logic                    r_neg;
    logic [MAG_W-1:0]        r_mag;
    logic [PLO_W-1:0]        r_plo;
    logic [PHI_W-1:0]        r_phi;
    logic signed [POW_W-1:0] r_power;

    assign dot     = DOT_W'(i_prod_x) + DOT_W'(i_prod_y) + DOT_W'(i_prod_z);
    assign dot_abs = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);

    assign full    = (FULL_W'(r_phi) << LO_W) + FULL_W'(r_plo);
    assign sat_pos = |full[FULL_W-1:POW_W-1];
    assign sat_neg = (|full[FULL_W-1:POW_W]) || (full[POW_W-1] && (|full[POW_W-2:0]));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.merge) begin
            r_neg <= dot[DOT_W-1];
            r_mag <= dot_abs[MAG_W-1:0];
        end
        if (i_ctrl.mul_lo) begin
            r_plo <= PLO_W'(r_mag[LO_W-1:0]) * PLO_W'(i_rate);
        end
        if (i_ctrl.mul_hi) begin
            r_phi <= PHI_W'(r_mag[MAG_W-1:LO_W]) * PHI_W'(i_rate);
        end
        if (i_ctrl.sat) begin
            if (r_neg) begin
                r_power <= sat_neg ? {1'b1, {(POW_W-1){1'b0}}} : -full[POW_W-1:0];
            end else begin
                r_power <= sat_pos ? {1'b0, {(POW_W-1){1'b1}}} : full[POW_W-1:0];
            end
        end
    end

    assign o_power = r_power;

endmodule

@@ hw/rtl/mpwa_div.sv @@
// ----------------------------------------------------------------------------
// mpwa_div
// Restoring divider for the window mean: DIV_BITS quotient bits per cycle,
// narrow divisor (the fill count).
// ----------------------------------------------------------------------------
module mpwa_div
    import mpwa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [SUM_W-1:0]  o_quotient
);

    logic [DIV_PAD_W-1:0] r_work;
    logic [CNT_W:0]       r_rem;
    logic [CNT_W-1:0]     r_divisor;
    logic [DCNT_W-1:0]    r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_PAD_W-1:0] n_work;
    logic [CNT_W:0]       n_rem;

    // DIV_BITS shift-subtract steps on the narrow remainder
    always_comb begin
        n_work = r_work;
        n_rem  = r_rem;
        for (int i = 0; i < DIV_BITS; i++) begin
            n_rem  = {n_rem[CNT_W-1:0], n_work[DIV_PAD_W-1]};
            n_work = {n_work[DIV_PAD_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_divisor}) begin
                n_rem     = n_rem - {1'b0, r_divisor};
                n_work[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work    <= DIV_PAD_W'(i_dividend);
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_work[SUM_W-1:0];

endmodule

@@ hw/rtl/mechanical_power_window_average_core.sv @@
// ----------------------------------------------------------------------------
// mechanical_power_window_average_core
// Steps in turn: input register, lanes, merge, two-part rate multiply,
//   saturation, window update and the 7-step mean divider. A new sample is
//   taken only when the last one has reached the output register.
// A finished result waits in the output register while the next item runs.
// Reset (synchronous, active low): sample rate 1000, window empty.
// ----------------------------------------------------------------------------
module mechanical_power_window_average_core
    import mpwa_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // sample channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [POS_W-1:0]   i_pos_x,
    input  logic signed [POS_W-1:0]   i_pos_y,
    input  logic signed [POS_W-1:0]   i_pos_z,
    input  logic signed [FRC_W-1:0]   i_force_x,
    input  logic signed [FRC_W-1:0]   i_force_y,
    input  logic signed [FRC_W-1:0]   i_force_z,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [AVG_W-1:0]          o_avg_power_abs,
    output logic signed [POW_W-1:0]   o_inst_power,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    t_state r_state, n_state;

    logic [RATE_W-1:0]        r_rate;
    logic                     r_started;
    logic                     r_first;
    logic signed [POS_W-1:0]  r_pos_x, r_pos_y, r_pos_z;
    logic signed [FRC_W-1:0]  r_force_x, r_force_y, r_force_z;
    logic signed [POS_W-1:0]  r_last_x, r_last_y, r_last_z;
    logic signed [POW_W-1:0]  r_ring [WINDOW];
    logic [IDX_W-1:0]         r_head;
    logic [CNT_W-1:0]         r_fill;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [POW_W-1:0]  r_power;
    logic                     r_out_valid;
    logic [AVG_W-1:0]         r_out_avg;
    logic signed [POW_W-1:0]  r_out_power;

    logic                     in_xfer;
    logic                     out_xfer;
    logic                     out_free;
    logic                     lane_en;
    logic                     div_start;
    logic                     div_done;
    t_scale_ctrl              scale_ctrl;
    logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
    logic signed [POW_W-1:0]  scaled_power;
    logic signed [POW_W-1:0]  new_power;
    logic signed [SUM_W-1:0]  leaving;
    logic                     full;
    logic [SUM_W-1:0]         sum_mag;
    logic [SUM_W-1:0]         quotient;
    logic [AVG_W-1:0]         avg_sat;
    logic                     cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_SAMPLE_RATE) ? PDATA_W'(r_rate) : '0;

    assign o_stall  = (r_state != S_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || !i_stall;

    assign full      = (r_fill == CNT_W'(WINDOW));
    assign new_power = r_first ? '0 : scaled_power;
    assign leaving   = full ? SUM_W'(r_ring[r_head]) : '0;
    assign sum_mag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign avg_sat   = (|quotient[SUM_W-1:AVG_W]) ? AVG_MAX : quotient[AVG_W-1:0];

    // ---------------------------------------------------------------- lanes
    mpwa_lane u_lane_x (
        .i_clk   (i_clk),
        .i_en    (lane_en),
        .i_pos   (r_pos_x),
        .i_last  (r_last_x),
        .i_force (r_force_x),
        .o_prod  (prod_x)
    );

    mpwa_lane u_lane_y (
        .i_clk   (i_clk),
        .i_en    (lane_en),
        .i_pos   (r_pos_y),
        .i_last  (r_last_y),
        .i_force (r_force_y),
        .o_prod  (prod_y)
    );

    mpwa_lane u_lane_z (
        .i_clk   (i_clk),
        .i_en    (lane_en),
        .i_pos   (r_pos_z),
        .i_last  (r_last_z),
        .i_force (r_force_z),
        .o_prod  (prod_z)
    );

    mpwa_scale u_scale (
        .i_clk    (i_clk),
        .i_ctrl   (scale_ctrl),
        .i_prod_x (prod_x),
        .i_prod_y (prod_y),
        .i_prod_z (prod_z),
        .i_rate   (r_rate),
        .o_power  (scaled_power)
    );

    mpwa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_mag),
        .i_divisor  (r_fill),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        lane_en    = 1'b0;
        div_start  = 1'b0;
        scale_ctrl = '0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_LANE;
                end
            end
            S_LANE: begin
                lane_en = 1'b1;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                scale_ctrl.merge = 1'b1;
                n_state          = S_MUL_LO;
            end
            S_MUL_LO: begin
                scale_ctrl.mul_lo = 1'b1;
                n_state           = S_MUL_HI;
            end
            S_MUL_HI: begin
                scale_ctrl.mul_hi = 1'b1;
                n_state           = S_SAT;
            end
            S_SAT: begin
                scale_ctrl.sat = 1'b1;
                n_state        = S_PUSH;
            end
            S_PUSH: begin
                n_state = S_START;
            end
            S_START: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= RATE_RESET;
            r_started   <= 1'b0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_last_z    <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr && paddr[2] == REG_SAMPLE_RATE) begin
                r_rate <= pwdata[RATE_W-1:0];
            end
            if (r_state == S_LANE) begin
                // lanes take the old position at this edge
                r_last_x  <= r_pos_x;
                r_last_y  <= r_pos_y;
                r_last_z  <= r_pos_z;
                r_started <= 1'b1;
            end
            if (r_state == S_PUSH) begin
                r_sum  <= r_sum - leaving + SUM_W'(new_power);
                r_head <= (r_head == IDX_W'(WINDOW - 1)) ? '0 : r_head + 1'b1;
                if (!full) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pos_x   <= i_pos_x;
            r_pos_y   <= i_pos_y;
            r_pos_z   <= i_pos_z;
            r_force_x <= i_force_x;
            r_force_y <= i_force_y;
            r_force_z <= i_force_z;
            r_first   <= !r_started;
        end
        if (r_state == S_PUSH) begin
            r_ring[r_head] <= new_power;
            r_power        <= new_power;
        end
        if (r_state == S_OUT && out_free) begin
            r_out_avg   <= avg_sat;
            r_out_power <= r_power;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_avg_power_abs = r_out_avg;
    assign o_inst_power    = r_out_power;

endmodule

@@ hw/rtl/mpwa_checker.sv @@
// ----------------------------------------------------------------------------
// mpwa_checker
// Port-level checks of the windowed power average core, bound to the top.
// ----------------------------------------------------------------------------
module mpwa_checker
    import mpwa_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      o_stall,
    input  logic                      o_valid,
    input  logic                      i_stall,
    input  logic [AVG_W-1:0]          o_avg_power_abs,
    input  logic signed [POW_W-1:0]   o_inst_power,
    input  logic                      psel,
    input  logic                      pready
);

    // nothing left over from before reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // one sample at a time: a transfer closes the input side
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input open right after a sample transfer");

    // a new result only comes out of a busy core
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared with no sample in flight");

    // held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_avg_power_abs)
            && $stable(o_inst_power))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel |-> pready)
        else $error("configuration port not ready");

endmodule

bind mechanical_power_window_average_core mpwa_checker u_mpwa_checker (.*);
